// ----- hw/rtl/qpht_pkg.sv -----
// Shared constants, request/response types and sequencer states for the hash table.
package qpht_pkg;

    localparam int TABLE_SIZE = 128;
    localparam int KEY_BITS   = 64;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int HOME_W = 7;
    localparam int POS_W = (IDX_W > HOME_W) ? IDX_W : HOME_W;
    localparam int PRB_W = $clog2(TABLE_SIZE + 1);
    localparam int SUM_W = ((POS_W > PRB_W) ? POS_W : PRB_W) + 1;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        OC_OK   = 2'd0,
        OC_MISS = 2'd1,
        OC_FULL = 2'd2
    } t_outcome;

    typedef struct packed {
        t_action     action;
        logic [6:0]  home_index;
        logic [63:0] key;
    } t_req;

    typedef struct packed {
        t_outcome   outcome;
        logic [6:0] slot_index;
        logic [7:0] entry_count;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_CMP
    } t_state;

endpackage

// ----- hw/rtl/qpht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/quadratic_probe_hash_table_core.sv -----
// Open-addressing hash table with quadratic probing: insert and search of fixed-width keys.
// Requests are taken one at a time; o_req_ready is high only while the sequencer is idle.
// A request passes ST_REDUCE, then ST_READ and ST_CMP for each slot examined, and ends
// with a loaded response register. The number of slots examined runs from 1 up to
// TABLE_SIZE+1; ST_REDUCE subtracts TABLE_SIZE from the home slot until it is below
// TABLE_SIZE (no subtraction at the default size). The sequencer is back in idle as the
// response register is loaded; ST_CMP waits while the previous response is not taken.
// Each probe needs ST_READ and ST_CMP because the key store has one registered read port.
// The response register frees the sequencer, so a new request is taken while the
// previous response still waits. Slot valid bits are all cleared at reset.
module quadratic_probe_hash_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  qpht_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output qpht_pkg::t_rsp o_rsp
);
    import qpht_pkg::*;

    t_state              r_state, n_state;
    t_action             r_action, n_action;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [PRB_W-1:0]    r_probes, n_probes;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [PRB_W-1:0]    r_count, n_count;
    logic [TABLE_SIZE-1:0] r_valid;
    t_rsp                r_rsp, n_rsp;
    logic                r_rsp_valid, n_rsp_valid;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [KEY_BITS-1:0] ram_rd_data;
    logic                valid_set;
    logic                slot_valid;
    logic                hit;
    logic                done;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    sum_mod;

    qpht_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_key_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_pos[IDX_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_pos[IDX_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign slot_valid = r_valid[r_pos[IDX_W-1:0]];
    assign hit        = slot_valid && (ram_rd_data == r_key);
    assign done       = !slot_valid || hit || (r_probes == PRB_W'(TABLE_SIZE));
    assign sum        = SUM_W'(r_pos) + SUM_W'(r_probes) + SUM_W'(1);
    assign sum_mod    = (sum >= SUM_W'(TABLE_SIZE)) ? (sum - SUM_W'(TABLE_SIZE)) : sum;

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_key       = r_key;
        n_count     = r_count;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        valid_set   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_action = i_req.action;
                    n_pos    = POS_W'(i_req.home_index);
                    n_key    = i_req.key[KEY_BITS-1:0];
                    n_probes = '0;
                    n_state  = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if ({1'b0, r_pos} >= (POS_W + 1)'(TABLE_SIZE)) begin
                    n_pos = r_pos - POS_W'(TABLE_SIZE);
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                ram_rd_en = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                if (!done) begin
                    n_probes = r_probes + PRB_W'(1);
                    n_pos    = POS_W'(sum_mod);
                    n_state  = ST_READ;
                end else if (!r_rsp_valid || i_rsp_ready) begin
                    n_count = r_count;
                    if (r_action == ACT_SEARCH) begin
                        n_rsp.outcome = hit ? OC_OK : OC_MISS;
                    end else if (!slot_valid) begin
                        ram_wr_en     = 1'b1;
                        valid_set     = 1'b1;
                        n_count       = r_count + PRB_W'(1);
                        n_rsp.outcome = OC_OK;
                    end else if (hit) begin
                        n_rsp.outcome = OC_MISS;
                    end else begin
                        n_rsp.outcome = OC_FULL;
                    end
                    n_rsp.slot_index  = 7'(r_pos);
                    n_rsp.entry_count = 8'(n_count);
                    n_rsp_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
            if (valid_set) begin
                r_valid[r_pos[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_pos    <= n_pos;
        r_probes <= n_probes;
        r_key    <= n_key;
        r_rsp    <= n_rsp;
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
